>>> rtl/egnt_pkg.sv
package egnt_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [8:0]  RST_THRESHOLD    = 9'd128;
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd2048;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd2048;

    localparam logic [7:0] PIX_BLACK = 8'd0;
    localparam logic [7:0] PIX_WHITE = 8'd255;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [7:0] intensity;
        logic [7:0] contour;
    } t_in_req;

    typedef struct packed {
        logic [7:0] result_value;
        logic       end_of_row;
        logic       end_of_frame;
    } t_out_req;

    // One column of the line stores: edge flag two rows up, edge flag one
    // row up and the threshold flag one row up.
    typedef struct packed {
        logic upper;
        logic middle;
        logic over_thr;
    } t_line_ent;

endpackage

>>> rtl/edge_growth_neighbour_threshold.sv
// Channel   Valid        Stall        Request
// input     i_in_valid   o_in_stall   i_in_req  (operation, intensity, contour)
// output    o_out_valid  i_out_stall  o_out_req (result_value, end_of_row, end_of_frame)
// config    i_cfg_we     -            i_cfg_index, i_cfg_data
//
// One request per clock unless stalled; results pass stage-1 and output registers.
// The line store has one read and one write port, which sets the one-per-clock rate.
// Results lag the input by one row; flush requests drive out the last row.
// Reset is synchronous; the line store is not cleared and needs no clearing pass.
// A stalled output holds the input side only once the internal stage is also full.
module edge_growth_neighbour_threshold #(
    parameter int MAX_WIDTH  = egnt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = egnt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  egnt_pkg::t_in_req                  i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output egnt_pkg::t_out_req                 o_out_req,
    input  logic                               i_cfg_we,
    input  logic [egnt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [egnt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import egnt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [8:0]            r_threshold;
    logic [11:0]           r_frame_width;
    logic [11:0]           r_frame_height;

    logic [CW-1:0]         r_col;
    logic [HW-1:0]         r_row;
    logic                  r_done;

    logic                  r_s1_vld;
    logic                  r_s1_wr;
    logic                  r_s1_res;
    logic                  r_s1_above;
    logic                  r_s1_left_ok;
    logic                  r_s1_right_ok;
    logic                  r_s1_eor;
    logic                  r_s1_eof;
    logic                  r_s1_edge;
    logic                  r_s1_strong;
    logic [CW-1:0]         r_s1_col;

    t_line_ent             r_cur;
    logic                  r_left;

    logic                  r_out_vld;
    t_out_req              r_out;

    logic [WW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;
    logic [WW-1:0]         col_p1;
    logic                  col_eor;
    logic [CW-1:0]         col_next;
    logic [HW-1:0]         row_p1;

    logic                  in_acc;
    logic                  pix_go;
    logic                  flush_go;
    logic                  active;
    logic                  out_free;
    logic                  s1_go;
    logic                  nb;

    t_line_ent             rd_data;
    t_line_ent             wr_data;
    logic                  wr_en;

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_frame_height);
        end
    end

    assign col_p1   = WW'(r_col) + WW'(1);
    assign col_eor  = (col_p1 == eff_w);
    assign col_next = col_eor ? '0 : CW'(col_p1);
    assign row_p1   = r_row + HW'(1);

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_go      = r_s1_vld && (!r_s1_res || out_free);
    assign o_in_stall = r_s1_vld && !s1_go;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign pix_go   = in_acc && (i_in_req.operation == OP_PIXEL) && !r_done;
    assign flush_go = in_acc && (i_in_req.operation == OP_FLUSH) && r_done;
    assign active   = pix_go || flush_go;

    assign wr_en            = s1_go && r_s1_wr;
    assign wr_data.upper    = r_cur.middle;
    assign wr_data.middle   = r_s1_edge;
    assign wr_data.over_thr = r_s1_strong;

    egnt_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (active),
        .i_rd_addr (col_next),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data)
    );

    assign nb = (r_s1_above && r_cur.upper)
             || (r_s1_wr && r_s1_edge)
             || (r_s1_left_ok && r_left)
             || (r_s1_right_ok && rd_data.middle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= RST_THRESHOLD;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
            r_done         <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[8:0];
                end
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                    r_col         <= '0;
                    r_row         <= '0;
                    r_done        <= 1'b0;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                    r_col          <= '0;
                    r_row          <= '0;
                    r_done         <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (pix_go) begin
            r_col <= col_next;
            if (col_eor) begin
                r_row <= row_p1;
                if (row_p1 >= eff_h) begin
                    r_done <= 1'b1;
                end
            end
        end else if (flush_go) begin
            r_col <= col_next;
            if (col_eor) begin
                r_row  <= '0;
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_s1_wr       <= pix_go;
            r_s1_res      <= flush_go || (r_row != '0);
            r_s1_above    <= pix_go ? (r_row > HW'(1)) : (eff_h > HW'(1));
            r_s1_left_ok  <= (r_col != '0);
            r_s1_right_ok <= !col_eor;
            r_s1_eor      <= col_eor;
            r_s1_eof      <= flush_go && col_eor;
            r_s1_edge     <= (i_in_req.contour == 8'd0);
            r_s1_strong   <= ({1'b0, i_in_req.intensity} >= r_threshold);
            r_s1_col      <= r_col;
        end
        // With a one-pixel row the next request reads the column just written.
        if (s1_go) begin
            r_left <= r_cur.middle;
            if (r_s1_wr && (eff_w == WW'(1))) begin
                r_cur <= wr_data;
            end else begin
                r_cur <= rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && r_s1_res) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_res) begin
            r_out.result_value <= (r_cur.over_thr && nb) ? PIX_BLACK : PIX_WHITE;
            r_out.end_of_row   <= r_s1_eor;
            r_out.end_of_frame <= r_s1_eof;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

endmodule

>>> rtl/egnt_line_mem.sv
module egnt_line_mem #(
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output egnt_pkg::t_line_ent o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  egnt_pkg::t_line_ent i_wr_data
);
    import egnt_pkg::*;

    t_line_ent r_mem [DEPTH];
    t_line_ent r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read of the entry written at the same edge returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_q <= i_wr_data;
            end else begin
                r_q <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q;

endmodule
